FILE: hw/rtl/rsu_pkg.sv
package rsu_pkg;

    // Operation codes of the rotate and shift unit.
    typedef enum logic [3:0] {
        OP_RLC = 4'd0,
        OP_RRC = 4'd1,
        OP_RL  = 4'd2,
        OP_RR  = 4'd3,
        OP_SLA = 4'd4,
        OP_SRA = 4'd5,
        OP_SRL = 4'd6,
        OP_RLD = 4'd7,
        OP_RRD = 4'd8
    } op_t;

    // Processor flag bits as they travel down the pipeline.
    typedef struct packed {
        logic sign;
        logic zero;
        logic half;
        logic xflag;
        logic parity;
        logic subtract;
        logic carry;
    } flags_t;

    // Request as captured at the input.
    typedef struct packed {
        op_t        op;
        logic [7:0] operand;
        logic [7:0] acc;
        logic       update;
        flags_t     flags;
    } s1_t;

    // Request after the rotate or shift; carry is already the new carry.
    typedef struct packed {
        logic       byte_op;
        logic       nibble_op;
        logic       update;
        logic [7:0] result;
        logic [7:0] acc;
        flags_t     flags;
    } s2_t;

    // Finished result.
    typedef struct packed {
        logic [7:0] result;
        logic [7:0] acc;
        flags_t     flags;
    } s3_t;

    // Parity flag convention: 1 on an even number of set bits.
    function automatic logic even_parity(input logic [7:0] value);
        even_parity = ~(^value);
    endfunction

endpackage

FILE: hw/rtl/rotate_shift_unit_8bit.sv
// Rotate and shift unit, three register stages: capture, rotate/shift, flags.
// Throughput is one request per cycle unless a stall reaches the input; a
// stalled stage holds only itself and the full stages behind it, so bubbles
// are squeezed out.
// Reset (rst_n low, asynchronous) clears the valid bit of every stage.
module rotate_shift_unit_8bit (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] operation,
    input  logic [7:0] operand,
    input  logic [7:0] acc_in,
    input  logic       update_sign_zero,
    input  logic       sign_in,
    input  logic       zero_in,
    input  logic       half_in,
    input  logic       xflag_in,
    input  logic       parity_in,
    input  logic       subtract_in,
    input  logic       carry_in,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] result,
    output logic [7:0] acc_out,
    output logic       sign_out,
    output logic       zero_out,
    output logic       half_out,
    output logic       xflag_out,
    output logic       parity_out,
    output logic       subtract_out,
    output logic       carry_out
);

    logic          s1_valid_reg;
    logic          s2_valid_reg;
    logic          s3_valid_reg;
    rsu_pkg::s1_t  s1_reg;
    rsu_pkg::s1_t  s1_next;
    rsu_pkg::s2_t  s2_reg;
    rsu_pkg::s2_t  s2_next;
    rsu_pkg::s3_t  s3_reg;
    rsu_pkg::s3_t  s3_next;
    logic          s1_hold;
    logic          s2_hold;
    logic          s3_hold;

    // A stage holds when it is full and the stage after it holds.
    assign s3_hold  = s3_valid_reg & out_stall;
    assign s2_hold  = s2_valid_reg & s3_hold;
    assign s1_hold  = s1_valid_reg & s2_hold;
    assign in_stall = s1_hold;

    // Valid bits move forward whenever the receiving stage is not holding.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_hold)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!s2_hold)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (!s3_hold)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: capture the request.
    always_comb
    begin
        s1_next.op             = rsu_pkg::op_t'(operation);
        s1_next.operand        = operand;
        s1_next.acc            = acc_in;
        s1_next.update         = update_sign_zero;
        s1_next.flags.sign     = sign_in;
        s1_next.flags.zero     = zero_in;
        s1_next.flags.half     = half_in;
        s1_next.flags.xflag    = xflag_in;
        s1_next.flags.parity   = parity_in;
        s1_next.flags.subtract = subtract_in;
        s1_next.flags.carry    = carry_in;
    end

    // Stage 2: rotate or shift the operand and form the new carry.
    always_comb
    begin
        s2_next.byte_op   = 1'b0;
        s2_next.nibble_op = 1'b0;
        s2_next.update    = s1_reg.update;
        s2_next.result    = s1_reg.operand;
        s2_next.acc       = s1_reg.acc;
        s2_next.flags     = s1_reg.flags;
        unique case (s1_reg.op)
            rsu_pkg::OP_RLC:
            begin
                s2_next.byte_op     = 1'b1;
                s2_next.result      = {s1_reg.operand[6:0], s1_reg.operand[7]};
                s2_next.flags.carry = s1_reg.operand[7];
            end
            rsu_pkg::OP_RRC:
            begin
                s2_next.byte_op     = 1'b1;
                s2_next.result      = {s1_reg.operand[0], s1_reg.operand[7:1]};
                s2_next.flags.carry = s1_reg.operand[0];
            end
            rsu_pkg::OP_RL:
            begin
                s2_next.byte_op     = 1'b1;
                s2_next.result      = {s1_reg.operand[6:0], s1_reg.flags.carry};
                s2_next.flags.carry = s1_reg.operand[7];
            end
            rsu_pkg::OP_RR:
            begin
                s2_next.byte_op     = 1'b1;
                s2_next.result      = {s1_reg.flags.carry, s1_reg.operand[7:1]};
                s2_next.flags.carry = s1_reg.operand[0];
            end
            rsu_pkg::OP_SLA:
            begin
                s2_next.byte_op     = 1'b1;
                s2_next.result      = {s1_reg.operand[6:0], 1'b0};
                s2_next.flags.carry = s1_reg.operand[7];
            end
            rsu_pkg::OP_SRA:
            begin
                s2_next.byte_op     = 1'b1;
                s2_next.result      = {s1_reg.operand[7], s1_reg.operand[7:1]};
                s2_next.flags.carry = s1_reg.operand[0];
            end
            rsu_pkg::OP_SRL:
            begin
                s2_next.byte_op     = 1'b1;
                s2_next.result      = {1'b0, s1_reg.operand[7:1]};
                s2_next.flags.carry = s1_reg.operand[0];
            end
            rsu_pkg::OP_RLD:
            begin
                s2_next.nibble_op = 1'b1;
                s2_next.acc       = {s1_reg.acc[7:4], s1_reg.operand[7:4]};
                s2_next.result    = {s1_reg.operand[3:0], s1_reg.acc[3:0]};
            end
            rsu_pkg::OP_RRD:
            begin
                s2_next.nibble_op = 1'b1;
                s2_next.acc       = {s1_reg.acc[7:4], s1_reg.operand[3:0]};
                s2_next.result    = {s1_reg.acc[3:0], s1_reg.operand[7:4]};
            end
            default:
            begin
                // Unused codes pass everything through unchanged.
                s2_next.byte_op = 1'b0;
            end
        endcase
    end

    // Stage 3: sign, zero and parity flags; half and subtract cleared, xflag too on nibble rotates.
    always_comb
    begin
        s3_next.result = s2_reg.result;
        s3_next.acc    = s2_reg.acc;
        s3_next.flags  = s2_reg.flags;
        if (s2_reg.byte_op)
        begin
            s3_next.flags.half     = 1'b0;
            s3_next.flags.subtract = 1'b0;
            if (s2_reg.update)
            begin
                s3_next.flags.sign   = s2_reg.result[7];
                s3_next.flags.zero   = (s2_reg.result == 8'h00);
                s3_next.flags.parity = rsu_pkg::even_parity(s2_reg.result);
            end
        end
        else if (s2_reg.nibble_op)
        begin
            s3_next.flags.half     = 1'b0;
            s3_next.flags.xflag    = 1'b0;
            s3_next.flags.subtract = 1'b0;
            s3_next.flags.parity   = rsu_pkg::even_parity(s2_reg.acc);
        end
    end

    // Payload registers load when their stage takes a new request.
    always_ff @(posedge clk)
    begin
        if (in_valid && !s1_hold)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg && !s2_hold)
        begin
            s2_reg <= s2_next;
        end
        if (s2_valid_reg && !s3_hold)
        begin
            s3_reg <= s3_next;
        end
    end

    // Output ports.
    assign out_valid    = s3_valid_reg;
    assign result       = s3_reg.result;
    assign acc_out      = s3_reg.acc;
    assign sign_out     = s3_reg.flags.sign;
    assign zero_out     = s3_reg.flags.zero;
    assign half_out     = s3_reg.flags.half;
    assign xflag_out    = s3_reg.flags.xflag;
    assign parity_out   = s3_reg.flags.parity;
    assign subtract_out = s3_reg.flags.subtract;
    assign carry_out    = s3_reg.flags.carry;

endmodule

FILE: hw/rtl/rsu_checker.sv
module rsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] result,
    input logic [7:0] acc_out,
    input logic       carry_out
);

    // A stalled result stays on the output unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result) && $stable(acc_out)
            && $stable(carry_out))
    else $error("stalled result changed or was dropped");

    // The input only stalls when the output is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output could drain");

    // With the output not stalled meanwhile, an accepted request reaches the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted request did not reach the output in time");

endmodule

bind rotate_shift_unit_8bit rsu_checker u_rsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .acc_out   (acc_out),
    .carry_out (carry_out)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES = 80;

    // One request as offered to the unit.
    typedef struct {
        logic [3:0]      op;
        logic [7:0]      operand;
        logic [7:0]      acc;
        logic            update;
        rsu_pkg::flags_t flags;
    } shift_req_t;

    // One result as returned by the unit.
    typedef struct {
        logic [7:0]      result;
        logic [7:0]      acc;
        rsu_pkg::flags_t flags;
    } shift_res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [3:0] operation = '0;
    logic [7:0] operand = '0;
    logic [7:0] acc_in = '0;
    logic       update_sign_zero = 1'b0;
    logic       sign_in = 1'b0;
    logic       zero_in = 1'b0;
    logic       half_in = 1'b0;
    logic       xflag_in = 1'b0;
    logic       parity_in = 1'b0;
    logic       subtract_in = 1'b0;
    logic       carry_in = 1'b0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] result;
    logic [7:0] acc_out;
    logic       sign_out;
    logic       zero_out;
    logic       half_out;
    logic       xflag_out;
    logic       parity_out;
    logic       subtract_out;
    logic       carry_out;

    shift_req_t pending_reqs[$];
    shift_res_t expected_results[$];

    int error_count = 0;
    int reqs_accepted = 0;
    int cycle_count = 0;

    // Sender pacing.
    int  tx_gap = 0;
    bit  tx_burst = 1'b0;

    // Receiver pacing and the long hold-off.
    int  rx_wait = 0;
    bit  rx_burst = 1'b0;
    int  hold_left = 0;
    int  holds_done = 0;

    rotate_shift_unit_8bit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .operand          (operand),
        .acc_in           (acc_in),
        .update_sign_zero (update_sign_zero),
        .sign_in          (sign_in),
        .zero_in          (zero_in),
        .half_in          (half_in),
        .xflag_in         (xflag_in),
        .parity_in        (parity_in),
        .subtract_in      (subtract_in),
        .carry_in         (carry_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result           (result),
        .acc_out          (acc_out),
        .sign_out         (sign_out),
        .zero_out         (zero_out),
        .half_out         (half_out),
        .xflag_out        (xflag_out),
        .parity_out       (parity_out),
        .subtract_out     (subtract_out),
        .carry_out        (carry_out)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Computes the rotate or shift result and the new flags of one request.
    function automatic shift_res_t predict_shift(input shift_req_t q);
        shift_res_t e;
        logic [7:0] d;
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] acc;
        logic       c;
        d   = q.operand;
        a   = q.acc;
        r   = d;
        acc = a;
        c   = q.flags.carry;
        e.flags = q.flags;
        case (q.op)
            rsu_pkg::OP_RLC:
            begin
                r = {d[6:0], d[7]};
                c = d[7];
            end
            rsu_pkg::OP_RRC:
            begin
                r = {d[0], d[7:1]};
                c = d[0];
            end
            rsu_pkg::OP_RL:
            begin
                r = {d[6:0], q.flags.carry};
                c = d[7];
            end
            rsu_pkg::OP_RR:
            begin
                r = {q.flags.carry, d[7:1]};
                c = d[0];
            end
            rsu_pkg::OP_SLA:
            begin
                r = {d[6:0], 1'b0};
                c = d[7];
            end
            rsu_pkg::OP_SRA:
            begin
                r = {d[7], d[7:1]};
                c = d[0];
            end
            rsu_pkg::OP_SRL:
            begin
                r = {1'b0, d[7:1]};
                c = d[0];
            end
            rsu_pkg::OP_RLD:
            begin
                acc = {a[7:4], d[7:4]};
                r   = {d[3:0], a[3:0]};
            end
            rsu_pkg::OP_RRD:
            begin
                acc = {a[7:4], d[3:0]};
                r   = {a[3:0], d[7:4]};
            end
            default:
            begin
            end
        endcase
        // Byte operations clear H and N; S, Z and P follow the result only on request.
        if (q.op <= rsu_pkg::OP_SRL)
        begin
            e.flags.half     = 1'b0;
            e.flags.subtract = 1'b0;
            if (q.update)
            begin
                e.flags.sign   = r[7];
                e.flags.zero   = (r == 8'h00);
                e.flags.parity = ~^r;
            end
        end
        // Nibble rotates take parity from the new accumulator.
        else if (q.op == rsu_pkg::OP_RLD || q.op == rsu_pkg::OP_RRD)
        begin
            e.flags.half     = 1'b0;
            e.flags.xflag    = 1'b0;
            e.flags.subtract = 1'b0;
            e.flags.parity   = ~^acc;
        end
        e.flags.carry = c;
        e.result = r;
        e.acc    = acc;
        return e;
    endfunction

    task automatic add_req(input logic [3:0] op, input logic [7:0] data,
                           input logic [7:0] acc, input logic update,
                           input logic [6:0] flag_bits);
        shift_req_t q;
        q.op      = op;
        q.operand = data;
        q.acc     = acc;
        q.update  = update;
        q.flags   = rsu_pkg::flags_t'(flag_bits);
        pending_reqs.push_back(q);
    endtask

    // Random request: mostly defined operations, some unused codes, biased operands.
    function automatic shift_req_t random_req();
        shift_req_t q;
        if ($urandom_range(0, 9) == 0)
            q.op = 4'($urandom_range(9, 15));
        else
            q.op = 4'($urandom_range(0, 8));
        case ($urandom_range(0, 7))
            0: q.operand = 8'h00;
            1: q.operand = 8'hff;
            2: q.operand = 8'h80;
            3: q.operand = 8'h01;
            default: q.operand = 8'($urandom_range(0, 255));
        endcase
        q.acc    = 8'($urandom_range(0, 255));
        q.update = 1'($urandom_range(0, 1));
        q.flags  = rsu_pkg::flags_t'(7'($urandom_range(0, 127)));
        return q;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
        if (got !== want)
        begin
            $display("MISMATCH cycle %0d %s: got %h, want %h", cycle_count, name, got, want);
            error_count++;
        end
    endtask

    // Reset and stimulus; waits for the unit to drain, then gives the verdict.
    initial
    begin
        int op_i;
        // Every operation at both extremes of operand and flags.
        for (op_i = 0; op_i <= 8; op_i++)
        begin
            add_req(4'(op_i), 8'h00, 8'h00, 1'b1, 7'h00);
            add_req(4'(op_i), 8'hff, 8'hff, 1'b1, 7'h7f);
        end
        // Nibble rotates are unaffected by the update flag.
        add_req(rsu_pkg::OP_RLD, 8'h0f, 8'hf0, 1'b0, 7'h7f);
        add_req(rsu_pkg::OP_RRD, 8'hf0, 8'h0f, 1'b1, 7'h00);
        // Single-bit edges and the update flag off for a byte operation.
        add_req(rsu_pkg::OP_SRA, 8'h80, 8'h5a, 1'b0, 7'h55);
        add_req(rsu_pkg::OP_RL,  8'h80, 8'ha5, 1'b1, 7'h01);
        // Unused operation codes pass everything through.
        add_req(4'd9,  8'h3c, 8'hc3, 1'b1, 7'h2a);
        add_req(4'd15, 8'hff, 8'h00, 1'b1, 7'h55);
        repeat (RANDOM_REQS)
            pending_reqs.push_back(random_req());

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Driver: presents requests from the pending queue with random gaps.
    always @(posedge clk)
    begin
        shift_req_t q;
        bit accepted;
        if (rst_n)
        begin
            accepted = in_valid && !in_stall;
            if (accepted)
            begin
                q.op      = operation;
                q.operand = operand;
                q.acc     = acc_in;
                q.update  = update_sign_zero;
                q.flags   = {sign_in, zero_in, half_in, xflag_in,
                             parity_in, subtract_in, carry_in};
                expected_results.push_back(predict_shift(q));
                reqs_accepted++;
            end
            if (!in_valid || accepted)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    q = pending_reqs.pop_front();
                    operation        <= q.op;
                    operand          <= q.operand;
                    acc_in           <= q.acc;
                    update_sign_zero <= q.update;
                    sign_in          <= q.flags.sign;
                    zero_in          <= q.flags.zero;
                    half_in          <= q.flags.half;
                    xflag_in         <= q.flags.xflag;
                    parity_in        <= q.flags.parity;
                    subtract_in      <= q.flags.subtract;
                    carry_in         <= q.flags.carry;
                    in_valid         <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        tx_burst = ~tx_burst;
                    tx_gap = tx_burst ? 0 : $urandom_range(0, 14);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, twice during the run, so the pipeline backs up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (holds_done < 2 && reqs_accepted >= 250 + 350 * holds_done)
            begin
                hold_left  <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
            end
        end
    end

    // Monitor: checks each accepted result and paces the output stall.
    always @(posedge clk)
    begin
        shift_res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("UNEXPECTED result at cycle %0d: %h", cycle_count, result);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("result",   result,           want.result);
                    report_field("acc_out",  acc_out,          want.acc);
                    report_field("sign",     8'(sign_out),     8'(want.flags.sign));
                    report_field("zero",     8'(zero_out),     8'(want.flags.zero));
                    report_field("half",     8'(half_out),     8'(want.flags.half));
                    report_field("xflag",    8'(xflag_out),    8'(want.flags.xflag));
                    report_field("parity",   8'(parity_out),   8'(want.flags.parity));
                    report_field("subtract", 8'(subtract_out), 8'(want.flags.subtract));
                    report_field("carry",    8'(carry_out),    8'(want.flags.carry));
                end
                if ($urandom_range(0, 39) == 0)
                    rx_burst = ~rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
            end
            if (hold_left > 0)
                out_stall <= 1'b1;
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

endmodule

FILE: filelist.f
hw/rtl/rsu_pkg.sv
hw/rtl/rotate_shift_unit_8bit.sv
hw/rtl/rsu_checker.sv
dv/tb_top.sv
